[rtl/afr_pkg.sv]
// afr_pkg: types, codes and constants shared by the addressed frame receiver
// no dependencies
`default_nettype none

package afr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] CHECK_MOD = 8'd255;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST = 2'd2;

  localparam logic [7:0] MAGIC_RST = 8'd0;
  localparam logic [7:0] OWN_RST   = 8'd0;
  localparam logic [7:0] BCAST_RST = 8'd255;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_MAGIC = 4'd1,
    PH_DEST  = 4'd2,
    PH_SRC   = 4'd3,
    PH_DATA0 = 4'd4,
    PH_DATA1 = 4'd5,
    PH_DATA2 = 4'd6,
    PH_DATA3 = 4'd7,
    PH_CHECK = 4'd8
  } phase_t;

  typedef struct packed {
    logic clr;
    logic add;
  } csum_ctl_t;

  typedef struct packed {
    logic [7:0]  source_address;
    logic [7:0]  payload_0;
    logic [7:0]  payload_1;
    logic [7:0]  payload_2;
    logic [7:0]  payload_3;
    logic        checksum_ok;
    logic [15:0] frame_number;
  } result_t;

endpackage

`default_nettype wire

[rtl/afr_csum.sv]
// afr_csum: running checksum of the data bytes, kept reduced mod 255
// depends on afr_pkg
`default_nettype none

module afr_csum
  import afr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire csum_ctl_t ctl,
  input  wire logic [7:0] data_byte,
  output logic [7:0]     acc
);

  logic [7:0] acc_r;
  logic [7:0] acc_nxt;
  logic [8:0] sum;

  always_comb begin
    sum = {1'b0, acc_r} + {1'b0, data_byte};
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = 8'd0;
    end else if (ctl.add) begin
      if (sum >= {1'b0, CHECK_MOD}) begin
        acc_nxt = 8'(sum - {1'b0, CHECK_MOD});
      end else begin
        acc_nxt = sum[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 8'd0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

[rtl/afr_fsm.sv]
// afr_fsm: frame phase tracking, address filter, field latches and frame counter
// depends on afr_pkg
`default_nettype none

module afr_fsm
  import afr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] magic_byte,
  input  wire logic [7:0] own_address,
  input  wire logic [7:0] bcast_addr,
  input  wire logic [7:0] csum_acc,
  output csum_ctl_t       csum_ctl,
  output logic            emit,
  output result_t         result
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sender_r;
  logic [7:0]  payload_r [4];
  logic [15:0] frame_cnt_r;

  always_comb begin
    phase_nxt = phase_r;
    csum_ctl  = '0;
    unique case (phase_r)
      PH_MAGIC: begin
        if (data_byte == magic_byte) begin
          phase_nxt = PH_DEST;
        end else if (data_byte != SYNC_BYTE) begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_DEST: begin
        if (data_byte == own_address || data_byte == bcast_addr) begin
          phase_nxt = PH_SRC;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_SRC: begin
        phase_nxt    = PH_DATA0;
        csum_ctl.clr = fire;
      end
      PH_DATA0: begin
        phase_nxt    = PH_DATA1;
        csum_ctl.add = fire;
      end
      PH_DATA1: begin
        phase_nxt    = PH_DATA2;
        csum_ctl.add = fire;
      end
      PH_DATA2: begin
        phase_nxt    = PH_DATA3;
        csum_ctl.add = fire;
      end
      PH_DATA3: begin
        phase_nxt    = PH_CHECK;
        csum_ctl.add = fire;
      end
      PH_CHECK: begin
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = (data_byte == SYNC_BYTE) ? PH_MAGIC : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      sender_r    <= 8'd0;
      frame_cnt_r <= 16'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      if (phase_r == PH_SRC) begin
        sender_r <= data_byte;
      end
      if (phase_r == PH_CHECK) begin
        frame_cnt_r <= frame_cnt_r + 16'd1;
      end
    end
  end

  // data bytes, no reset needed
  always_ff @(posedge clk) begin
    if (fire) begin
      case (phase_r)
        PH_DATA0: payload_r[0] <= data_byte;
        PH_DATA1: payload_r[1] <= data_byte;
        PH_DATA2: payload_r[2] <= data_byte;
        PH_DATA3: payload_r[3] <= data_byte;
        default: ;
      endcase
    end
  end

  assign emit = (phase_r == PH_CHECK);

  always_comb begin
    result.source_address = sender_r;
    result.payload_0      = payload_r[0];
    result.payload_1      = payload_r[1];
    result.payload_2      = payload_r[2];
    result.payload_3      = payload_r[3];
    result.checksum_ok    = (data_byte == csum_acc);
    result.frame_number   = frame_cnt_r;
  end

endmodule

`default_nettype wire

[rtl/addressed_frame_receiver.sv]
// addressed_frame_receiver: top level with input register, config registers
// and result register; depends on afr_pkg, afr_csum, afr_fsm
//
// Usage:
//   in_valid/in_ready/in_rx_byte carries one received serial byte per
//   transaction. Frames are sync 0xFF, magic, destination, source, four data
//   bytes, checksum. Extra 0xFF bytes before the magic byte are skipped.
//   Frames whose destination matches neither own nor broadcast address are
//   dropped and the receiver hunts for sync again.
//   out_valid/out_ready carries one result per completed frame, on its
//   checksum byte: source, four data bytes, checksum_ok and frame_number.
//   cfg_we/cfg_index/cfg_wdata writes magic (0), own (1) and broadcast (2)
//   addresses; write only while no frame byte is in flight.
// Timing:
//   one byte per cycle sustained unless a result waits on out_ready; set by
//   the phase register stepping once per byte. out_valid is registered.
// Reset (rst_n low, synchronous): phase returns to sync hunt, frame counter
//   and sender clear, config returns to magic 0, own 0, broadcast 0xFF.
// Stall: while a result waits on out_ready, non-checksum bytes still flow;
//   the next checksum byte holds in the input register and in_ready drops.
`default_nettype none

module addressed_frame_receiver
  import afr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_source_address,
  output logic [7:0]                out_payload_0,
  output logic [7:0]                out_payload_1,
  output logic [7:0]                out_payload_2,
  output logic [7:0]                out_payload_3,
  output logic                      out_checksum_ok,
  output logic [15:0]               out_frame_number,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata
);

  logic       byte_vld_r;
  logic [7:0] byte_r;
  logic [7:0] magic_r, own_r, bcast_r;
  logic       out_vld_r;
  result_t    res_r;

  csum_ctl_t  csum_ctl;
  logic [7:0] csum_acc;
  logic       emit;
  result_t    res;
  logic       out_free;
  logic       fire;
  logic       in_fire;

  assign out_free = !out_vld_r || out_ready;
  assign fire     = byte_vld_r && (!emit || out_free);
  assign in_ready = !byte_vld_r || fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RST;
      own_r   <= OWN_RST;
      bcast_r <= BCAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAGIC: magic_r <= cfg_wdata;
        CFG_OWN:   own_r   <= cfg_wdata;
        CFG_BCAST: bcast_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_ready) begin
      byte_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_rx_byte;
    end
  end

  afr_csum u_csum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (csum_ctl),
    .data_byte (byte_r),
    .acc       (csum_acc)
  );

  afr_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data_byte   (byte_r),
    .magic_byte  (magic_r),
    .own_address (own_r),
    .bcast_addr  (bcast_r),
    .csum_acc    (csum_acc),
    .csum_ctl    (csum_ctl),
    .emit        (emit),
    .result      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_source_address = res_r.source_address;
  assign out_payload_0      = res_r.payload_0;
  assign out_payload_1      = res_r.payload_1;
  assign out_payload_2      = res_r.payload_2;
  assign out_payload_3      = res_r.payload_3;
  assign out_checksum_ok    = res_r.checksum_ok;
  assign out_frame_number   = res_r.frame_number;

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !byte_vld_r |-> in_ready)
    else $error("input stage empty but not ready");

  a_emit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit |=> out_vld_r)
    else $error("checksum byte consumed without result");

  a_held_byte_stable: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld_r && !fire |=> byte_vld_r && $stable(byte_r))
    else $error("held byte lost or changed");

  a_counter_steps: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit |=> res_r.frame_number == $past(res.frame_number))
    else $error("result frame number mismatch");

endmodule

`default_nettype wire
